// ===== hdl/kinematic_bicycle_step_defines.svh =====
// Assertion macros shared by the kinematic bicycle step RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef KINEMATIC_BICYCLE_STEP_DEFINES_SVH
`define KINEMATIC_BICYCLE_STEP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define KBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kbs assertion failed");
// Next-cycle implication.
`define KBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kbs assertion failed");
`else
`define KBS_ASSERT_IMP(lbl, ante, cons)
`define KBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/kbs_pkg.sv =====
`default_nettype none
package kbs_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 1'b1;

    localparam int DT_W   = 17;
    localparam int LF_W   = 23;
    localparam int DATA_W = 32;

    localparam logic [DT_W-1:0] DT_RESET = 17'd6554;
    localparam logic [LF_W-1:0] LF_RESET = 23'd174981;

    // Angle scale round(2^33/pi) and CORDIC gain 0.6072529 in Q30
    localparam logic [63:0] ANG_SCALE = 64'h00000000A2F9836E;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ATAN_N = 24;

    // Yaw-rate divider: quotient bits produced after the saturation check
    localparam int DIV_STAGES = 46;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Item as classified by the front
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] h;
        logic signed [31:0] v;
        logic signed [31:0] a;
        logic signed [33:0] z;
        logic               flip;
        logic [62:0]        pmag;
        logic               qneg;
        logic               qsat;
    } t_cmd;

    // One stage of the back pipeline (CORDIC and divider side by side)
    typedef struct packed {
        logic signed [31:0]    x;
        logic signed [31:0]    y;
        logic signed [31:0]    h;
        logic signed [31:0]    v;
        logic signed [31:0]    a;
        logic signed [33:0]    cx;
        logic signed [33:0]    cy;
        logic signed [33:0]    z;
        logic                  flip;
        logic                  qneg;
        logic                  qsat;
        logic [LF_W-1:0]       rem;
        logic [DIV_STAGES-1:0] pbits;
        logic [DIV_STAGES-1:0] quot;
    } t_stg;

    // atan(2^-i) as a binary angle, 2^32 per turn
    function automatic logic [31:0] kbs_atan(input int i);
        logic [31:0] r;
        begin
            unique case (i)
                0:  r = 32'h20000000;
                1:  r = 32'h12E4051E;
                2:  r = 32'h09FB385B;
                3:  r = 32'h051111D4;
                4:  r = 32'h028B0D43;
                5:  r = 32'h0145D7E1;
                6:  r = 32'h00A2F61E;
                7:  r = 32'h00517C55;
                8:  r = 32'h0028BE53;
                9:  r = 32'h00145F2F;
                10: r = 32'h000A2F98;
                11: r = 32'h000517CC;
                12: r = 32'h00028BE6;
                13: r = 32'h000145F3;
                14: r = 32'h0000A2FA;
                15: r = 32'h0000517D;
                16: r = 32'h000028BE;
                17: r = 32'h0000145F;
                18: r = 32'h00000A30;
                19: r = 32'h00000518;
                20: r = 32'h0000028C;
                21: r = 32'h00000146;
                22: r = 32'h000000A3;
                23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] kbs_sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        begin
            if (v > 67'sd2147483647) begin
                r = 32'sh7FFFFFFF;
            end else if (v < -67'sd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/kbs_in_if.sv =====
`default_nettype none
interface kbs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] steering_angle;
    logic signed [31:0] acceleration;

    modport source (
        output valid, x_position, y_position, heading, speed, steering_angle,
               acceleration,
        input  ready
    );
    modport sink (
        input  valid, x_position, y_position, heading, speed, steering_angle,
               acceleration,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/kbs_out_if.sv =====
`default_nettype none
interface kbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_heading;
    logic signed [31:0] next_speed;

    modport source (
        output valid, next_x, next_y, next_heading, next_speed,
        input  ready
    );
    modport sink (
        input  valid, next_x, next_y, next_heading, next_speed,
        output ready
    );
endinterface
`default_nettype wire

// ===== hdl/kbs_front.sv =====
`default_nettype none
`include "kinematic_bicycle_step_defines.svh"
module kbs_front import kbs_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [LF_W-1:0] i_lf,
    kbs_in_if.sink               i_item,
    input  wire logic            i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic               r_fv;
    logic [63:0]        r_hp;
    logic signed [63:0] r_pv;
    logic signed [31:0] r_x, r_y, r_h, r_v, r_a;

    logic        w_acc;
    logic [31:0] w_bam, w_bamf;
    logic        w_flip;
    logic [63:0] w_pabs;

    // Input register stage; refills as soon as its item moves into the queue
    assign i_item.ready = !r_fv || !i_full;
    assign w_acc        = i_item.valid && i_item.ready;
    assign o_push       = r_fv && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    // Heading to binary angle product and speed times steering
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_hp <= {{32{i_item.heading[31]}}, i_item.heading} * ANG_SCALE;
            r_pv <= 64'(i_item.speed) * 64'(i_item.steering_angle);
            r_x  <= i_item.x_position;
            r_y  <= i_item.y_position;
            r_h  <= i_item.heading;
            r_v  <= i_item.speed;
            r_a  <= i_item.acceleration;
        end
    end

    // Quadrant fold of the angle
    assign w_bam  = r_hp[FRAC_BITS+33:FRAC_BITS+2];
    assign w_flip = (w_bam + 32'h40000000) >= 32'h80000000;
    assign w_bamf = w_flip ? (w_bam - 32'h80000000) : w_bam;

    // Magnitude and saturation check of the yaw-rate dividend
    assign w_pabs = r_pv[63] ? (64'd0 - 64'(r_pv)) : 64'(r_pv);

    always_comb begin
        o_cmd.x    = r_x;
        o_cmd.y    = r_y;
        o_cmd.h    = r_h;
        o_cmd.v    = r_v;
        o_cmd.a    = r_a;
        o_cmd.z    = {{2{w_bamf[31]}}, w_bamf};
        o_cmd.flip = w_flip;
        o_cmd.pmag = w_pabs[62:0];
        o_cmd.qneg = r_pv[63];
        o_cmd.qsat = {6'd0, w_pabs[62:DIV_STAGES]} >= i_lf;
    end

    `KBS_ASSERT_IMP(a_front_hold, r_fv && i_full, !i_item.ready)

endmodule
`default_nettype wire

// ===== hdl/kbs_fifo.sv =====
`default_nettype none
`include "kinematic_bicycle_step_defines.svh"
module kbs_fifo import kbs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `KBS_ASSERT_IMP(a_fifo_bound, 1'b1, r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
    `KBS_ASSERT_NXT(a_fifo_up, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule
`default_nettype wire

// ===== hdl/kbs_back.sv =====
`default_nettype none
`include "kinematic_bicycle_step_defines.svh"
module kbs_back import kbs_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [DT_W-1:0] i_dt,
    input  wire logic [LF_W-1:0] i_lf,
    input  t_cmd                 i_cmd,
    input  wire logic            i_empty,
    output logic                 o_pop,
    kbs_out_if.source            o_result
);

    localparam logic signed [66:0] HALF_F = 67'sd1 <<< (FRAC_BITS - 1);

    t_stg                  r_stg [DIV_STAGES+1];
    t_stg                  w_nxt [DIV_STAGES+1];
    logic [DIV_STAGES:0]   r_vld;
    logic                  w_en;
    logic signed [17:0]    w_dt;

    // Stage A registers
    logic                  r_va;
    logic signed [65:0]    r_pc, r_ps;
    logic signed [64:0]    r_qdt;
    logic signed [49:0]    r_adt;
    logic signed [31:0]    r_ax, r_ay, r_ah, r_av;
    // Stage B registers
    logic                  r_vb;
    logic signed [51:0]    r_mcdt, r_msdt;
    logic signed [31:0]    r_bx, r_by, r_bh, r_bs;
    // Output register
    logic                  r_ov;
    logic signed [31:0]    r_ox, r_oy, r_oh, r_os;

    logic signed [33:0]    w_c, w_s;
    logic signed [46:0]    w_q;
    logic signed [65:0]    w_mc_r, w_ms_r;
    logic signed [33:0]    w_mc, w_ms;
    logic signed [66:0]    w_hsum, w_ssum, w_xsum, w_ysum;

    // Whole pipeline advances together; the queue absorbs the stall
    assign w_en  = !r_ov || o_result.ready;
    assign o_pop = w_en && !i_empty;
    assign w_dt  = $signed({1'b0, i_dt});

    // Stage 0 load from the queue
    always_comb begin
        w_nxt[0].x     = i_cmd.x;
        w_nxt[0].y     = i_cmd.y;
        w_nxt[0].h     = i_cmd.h;
        w_nxt[0].v     = i_cmd.v;
        w_nxt[0].a     = i_cmd.a;
        w_nxt[0].cx    = CORDIC_GAIN;
        w_nxt[0].cy    = '0;
        w_nxt[0].z     = i_cmd.z;
        w_nxt[0].flip  = i_cmd.flip;
        w_nxt[0].qneg  = i_cmd.qneg;
        w_nxt[0].qsat  = i_cmd.qsat;
        w_nxt[0].rem   = i_cmd.qsat ? '0 : {6'd0, i_cmd.pmag[62:DIV_STAGES]};
        w_nxt[0].pbits = i_cmd.pmag[DIV_STAGES-1:0];
        w_nxt[0].quot  = '0;
    end

    // One divider bit per stage; one CORDIC rotation in each of the first CORDIC_STAGES stages
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [LF_W:0] w_r2;
        logic          w_ge;
        logic [LF_W:0] w_sub;

        assign w_r2  = {r_stg[k].rem, r_stg[k].pbits[DIV_STAGES-1-k]};
        assign w_ge  = w_r2 >= {1'b0, i_lf};
        assign w_sub = w_r2 - {1'b0, i_lf};

        if (k < CORDIC_STAGES && k < ATAN_N) begin : g_rot
            logic signed [33:0] w_dx, w_dy, w_at;
            assign w_dx = r_stg[k].cy >>> k;
            assign w_dy = r_stg[k].cx >>> k;
            assign w_at = $signed({2'b00, kbs_atan(k)});

            always_comb begin
                w_nxt[k+1] = r_stg[k];
                w_nxt[k+1].rem = w_ge ? w_sub[LF_W-1:0] : w_r2[LF_W-1:0];
                w_nxt[k+1].quot[DIV_STAGES-1-k] = w_ge;
                if (!r_stg[k].z[33]) begin
                    w_nxt[k+1].cx = r_stg[k].cx - w_dx;
                    w_nxt[k+1].cy = r_stg[k].cy + w_dy;
                    w_nxt[k+1].z  = r_stg[k].z - w_at;
                end else begin
                    w_nxt[k+1].cx = r_stg[k].cx + w_dx;
                    w_nxt[k+1].cy = r_stg[k].cy - w_dy;
                    w_nxt[k+1].z  = r_stg[k].z + w_at;
                end
            end
        end else begin : g_pass
            always_comb begin
                w_nxt[k+1] = r_stg[k];
                w_nxt[k+1].rem = w_ge ? w_sub[LF_W-1:0] : w_r2[LF_W-1:0];
                w_nxt[k+1].quot[DIV_STAGES-1-k] = w_ge;
            end
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DIV_STAGES-1:0], !i_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stg <= w_nxt;
        end
    end

    // Stage A: undo the fold, saturate the yaw rate, products
    assign w_c = r_stg[DIV_STAGES].flip ? -r_stg[DIV_STAGES].cx : r_stg[DIV_STAGES].cx;
    assign w_s = r_stg[DIV_STAGES].flip ? -r_stg[DIV_STAGES].cy : r_stg[DIV_STAGES].cy;

    always_comb begin
        if (r_stg[DIV_STAGES].qsat) begin
            w_q = r_stg[DIV_STAGES].qneg ? -(47'sd1 <<< 46) : ((47'sd1 <<< 46) - 47'sd1);
        end else if (r_stg[DIV_STAGES].qneg) begin
            w_q = -$signed({1'b0, r_stg[DIV_STAGES].quot});
        end else begin
            w_q = $signed({1'b0, r_stg[DIV_STAGES].quot});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc  <= 66'(r_stg[DIV_STAGES].v) * 66'(w_c);
            r_ps  <= 66'(r_stg[DIV_STAGES].v) * 66'(w_s);
            r_qdt <= 65'(w_q) * 65'(w_dt);
            r_adt <= 50'(r_stg[DIV_STAGES].a) * 50'(w_dt);
            r_ax  <= r_stg[DIV_STAGES].x;
            r_ay  <= r_stg[DIV_STAGES].y;
            r_ah  <= r_stg[DIV_STAGES].h;
            r_av  <= r_stg[DIV_STAGES].v;
        end
    end

    // Stage B: round to speed components, scale by dt, finish heading and speed
    assign w_mc_r = (r_pc + (66'sd1 <<< 29)) >>> 30;
    assign w_ms_r = (r_ps + (66'sd1 <<< 29)) >>> 30;
    assign w_mc   = w_mc_r[33:0];
    assign w_ms   = w_ms_r[33:0];
    assign w_hsum = 67'(r_ah) + ((67'(r_qdt) + HALF_F) >>> FRAC_BITS);
    assign w_ssum = 67'(r_av) + ((67'(r_adt) + HALF_F) >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mcdt <= 52'(w_mc) * 52'(w_dt);
            r_msdt <= 52'(w_ms) * 52'(w_dt);
            r_bx   <= r_ax;
            r_by   <= r_ay;
            r_bh   <= kbs_sat32(w_hsum);
            r_bs   <= kbs_sat32(w_ssum);
        end
    end

    // Output register: position update
    assign w_xsum = 67'(r_bx) + ((67'(r_mcdt) + HALF_F) >>> FRAC_BITS);
    assign w_ysum = 67'(r_by) + ((67'(r_msdt) + HALF_F) >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ox <= kbs_sat32(w_xsum);
            r_oy <= kbs_sat32(w_ysum);
            r_oh <= r_bh;
            r_os <= r_bs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_va <= r_vld[DIV_STAGES];
            r_vb <= r_va;
            r_ov <= r_vb;
        end
    end

    assign o_result.valid        = r_ov;
    assign o_result.next_x       = r_ox;
    assign o_result.next_y       = r_oy;
    assign o_result.next_heading = r_oh;
    assign o_result.next_speed   = r_os;

    `KBS_ASSERT_IMP(a_out_src, $rose(r_ov), $past(r_vb))

endmodule
`default_nettype wire

// ===== hdl/kinematic_bicycle_step.sv =====
// Kinematic bicycle model, one time step per item.
// i_item carries a vehicle state (x, y, heading, speed) and the actuators
// (steering angle, acceleration), all signed Q16.16; o_result returns the
// next x, y, heading and speed, saturated to 32 bits. Both channels transfer
// when valid and ready are high at a rising edge; one result per item, in order.
// Configuration: i_cfg_we with i_cfg_idx 0 writes the time step dt, index 1
// the wheelbase; write only while no item is in flight.
// Throughput: one item per cycle while o_result.ready stays high. Items pass
// the input register, the queue, 46 divider stages and three
// multiply/round stages. The yaw-rate divider, one quotient bit per stage,
// sets the depth; CORDIC rotations run in the first CORDIC_STAGES of them.
// Reset (synchronous, active low) empties the pipeline and the queue and
// restores dt = 6554 and wheelbase = 174981.
// When the receiver stalls, the back pipeline holds, the four-entry queue
// fills, and i_item.ready drops once queue and input register are full.
`default_nettype none
module kinematic_bicycle_step import kbs_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LF_W-1:0]      i_cfg_data,
    kbs_in_if.sink                    i_item,
    kbs_out_if.source                 o_result
);

    logic [DT_W-1:0] r_dt;
    logic [LF_W-1:0] r_lf;
    logic [LF_W-1:0] w_lf;
    logic            w_full, w_empty, w_push, w_pop;
    t_cmd            w_fcmd, w_bcmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
            r_lf <= LF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP: r_dt <= i_cfg_data[DT_W-1:0];
                CFG_WHEELBASE: r_lf <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero wheelbase acts as one LSB
    assign w_lf = (r_lf == '0) ? LF_W'(1) : r_lf;

    kbs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lf    (w_lf),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_fcmd)
    );

    kbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_bcmd),
        .o_empty (w_empty)
    );

    kbs_back #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dt     (r_dt),
        .i_lf     (w_lf),
        .i_cmd    (w_bcmd),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
